@@ sv/bzp_pkg.sv @@
package bzp_pkg;

  localparam int unsigned CoordW   = 9;
  localparam int unsigned PosW     = 25;  // Q9.16 curve position
  localparam int unsigned CellW    = 14;  // signed neighbor cell coordinate
  localparam int unsigned SqrtIn   = 36;
  localparam int unsigned SQRT8_Q16 = 185363;
  localparam logic [63:0] S3 = 64'(SQRT8_Q16) * 64'(SQRT8_Q16) * 64'(SQRT8_Q16);
  localparam int unsigned NbLast   = 8;

  typedef enum logic {
    KIND_PLOT = 1'b0,
    KIND_READ = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic [PosW-1:0]     px;
    logic [PosW-1:0]     py;
    logic [CoordW-1:0]   rx;
    logic [CoordW-1:0]   ry;
  } job_t;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [7:0]        value;
    logic              last;
  } result_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_ADD,
    F_PUSH
  } front_state_e;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_SETUP,
    B_NB,
    B_SQX,
    B_SQY,
    B_ROOT,
    B_DIFF,
    B_SQR,
    B_CUBE,
    B_SCALE,
    B_SEARCH,
    B_WRITE,
    B_NEXT,
    B_RD_WAIT,
    B_RD_EMIT
  } back_state_e;

  // neighbor order: center, then around starting below
  function automatic logic signed [1:0] nb_dx(input logic [3:0] i);
    logic signed [1:0] r;
    unique case (i)
      4'd2, 4'd3, 4'd4: r = 2'sd1;
      4'd6, 4'd7, 4'd8: r = -2'sd1;
      default:          r = 2'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [1:0] nb_dy(input logic [3:0] i);
    logic signed [1:0] r;
    unique case (i)
      4'd1, 4'd2, 4'd8: r = 2'sd1;
      4'd4, 4'd5, 4'd6: r = -2'sd1;
      default:          r = 2'sd0;
    endcase
    return r;
  endfunction

endpackage

@@ sv/bezier_curve_antialiased_plotter.sv @@
// channel   | direction | handshake           | payload
// input     | in        | push / full         | kind_i, t_frac_i, read_x_i, read_y_i
// result    | out       | pop / empty         | pixel_x_o, pixel_y_o, pixel_value_o, last_o
// config    | in        | cfg_we_i, cfg_idx_i | cfg_data_i
//
// A plot transaction first runs twelve lerps (one multiplier, a multiply and an add
// state per lerp), then works on each in-frame neighbor (18 square-root steps, 8
// intensity search steps, one frame memory write port) and skips off-frame ones.
// A read transaction passes through setup, a memory read wait and an emit state.
// After reset the frame memory is cleared one entry a cycle, FRAME_WIDTH*FRAME_HEIGHT
// entries, with full held high; configuration writes are taken meanwhile.
// Front and back stall independently through a two-entry job queue; results
// wait in a two-entry output queue.
module bezier_curve_antialiased_plotter import bzp_pkg::*; #(
  parameter int unsigned FRAME_WIDTH  = 512,
  parameter int unsigned FRAME_HEIGHT = 512,
  parameter int unsigned T_FRAC_BITS  = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [CoordW-1:0] cfg_data_i,
  input  logic              push,
  output logic              full,
  input  logic              kind_i,
  input  logic [16:0]       t_frac_i,
  input  logic [CoordW-1:0] read_x_i,
  input  logic [CoordW-1:0] read_y_i,
  output logic              empty,
  input  logic              pop,
  output logic [CoordW-1:0] pixel_x_o,
  output logic [CoordW-1:0] pixel_y_o,
  output logic [7:0]        pixel_value_o,
  output logic              last_o
);

  logic    in_ready, clearing;
  logic    job_push, job_full, job_pop, job_empty;
  job_t    job_in, job_out;
  logic    res_push, res_full;
  result_t res_in, res_out;

  assign full = !in_ready || clearing;

  bzp_front #(.T_FRAC_BITS(T_FRAC_BITS)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i (push && !full),
    .in_ready_o (in_ready),
    .kind_i, .t_frac_i, .read_x_i, .read_y_i,
    .job_push_o (job_push),
    .job_o      (job_in),
    .job_full_i (job_full)
  );

  bzp_fifo #(.item_t(job_t)) u_job_q (
    .clk_i, .rst_ni,
    .push_i (job_push), .data_i (job_in), .full_o (job_full),
    .pop_i (job_pop), .data_o (job_out), .empty_o (job_empty)
  );

  bzp_back #(.FRAME_WIDTH(FRAME_WIDTH), .FRAME_HEIGHT(FRAME_HEIGHT)) u_back (
    .clk_i, .rst_ni,
    .clearing_o  (clearing),
    .job_empty_i (job_empty),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .res_full_i  (res_full)
  );

  bzp_fifo #(.item_t(result_t)) u_res_q (
    .clk_i, .rst_ni,
    .push_i (res_push), .data_i (res_in), .full_o (res_full),
    .pop_i (pop), .data_o (res_out), .empty_o (empty)
  );

  assign pixel_x_o     = res_out.x;
  assign pixel_y_o     = res_out.y;
  assign pixel_value_o = res_out.value;
  assign last_o        = res_out.last;

endmodule

@@ sv/bzp_fifo.sv @@
module bzp_fifo #(
  parameter type item_t = logic
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t data_o,
  output logic  empty_o
);

  item_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= !wp_q;
      if (do_pop)  rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("fifo count out of range");
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wp_q == rp_q)) else $error("fifo pointers");
  a_pop_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push) |=> (cnt_q == $past(cnt_q) - 2'd1)) else $error("fifo pop");

endmodule

@@ sv/bzp_front.sv @@
module bzp_front import bzp_pkg::*; #(
  parameter int unsigned T_FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [CoordW-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              kind_i,
  input  logic [16:0]       t_frac_i,
  input  logic [CoordW-1:0] read_x_i,
  input  logic [CoordW-1:0] read_y_i,
  output logic              job_push_o,
  output job_t              job_o,
  input  logic              job_full_i
);

  localparam int unsigned TW = T_FRAC_BITS + 1;
  localparam int unsigned PW = PosW + TW + 2;
  localparam logic [TW-1:0] One = TW'(1) << T_FRAC_BITS;

  front_state_e state_q, state_d;
  logic [CoordW-1:0] cfg_q [8];
  logic [TW-1:0]     t_q;
  kind_e             kind_q;
  logic [CoordW-1:0] rx_q, ry_q;
  logic [3:0]        step_q;
  logic [PosW-1:0]   lr_q [5];
  logic [PosW-1:0]   px_q, py_q;
  logic signed [PW-1:0] prod_q;

  logic              ysel;
  logic [2:0]        j;
  logic [PosW-1:0]   c [4];
  logic [PosW-1:0]   op_a, op_b;
  logic signed [PW-1:0] sum;
  logic [PosW-1:0]   lerp_res;

  always_comb begin
    ysel = (step_q >= 4'd6);
    j    = ysel ? 3'(step_q - 4'd6) : step_q[2:0];
    for (int k = 0; k < 4; k++) begin
      c[k] = {cfg_q[2*k + (ysel ? 1 : 0)], 16'b0};
    end
    unique case (j)
      3'd0:    begin op_a = c[0];     op_b = c[1];     end
      3'd1:    begin op_a = c[1];     op_b = c[2];     end
      3'd2:    begin op_a = c[2];     op_b = c[3];     end
      3'd3:    begin op_a = lr_q[0];  op_b = lr_q[1];  end
      3'd4:    begin op_a = lr_q[1];  op_b = lr_q[2];  end
      default: begin op_a = lr_q[3];  op_b = lr_q[4];  end
    endcase
    sum      = $signed({3'b0, op_a, {T_FRAC_BITS{1'b0}}}) + prod_q;
    lerp_res = sum[T_FRAC_BITS +: PosW];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: if (in_valid_i) state_d = (kind_i == KIND_READ) ? F_PUSH : F_MUL;
      F_MUL:  state_d = F_ADD;
      F_ADD:  state_d = (step_q == 4'd11) ? F_PUSH : F_MUL;
      F_PUSH: if (!job_full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == F_IDLE);
    job_push_o = (state_q == F_PUSH);
    job_o.kind = kind_q;
    job_o.px   = px_q;
    job_o.py   = py_q;
    job_o.rx   = rx_q;
    job_o.ry   = ry_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      for (int k = 0; k < 8; k++) cfg_q[k] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          kind_q <= kind_e'(kind_i);
          rx_q   <= read_x_i;
          ry_q   <= read_y_i;
          step_q <= 4'd0;
          // t above one saturates
          t_q    <= (32'(t_frac_i) > 32'(One)) ? One : TW'(t_frac_i);
        end
      end
      F_MUL: begin
        prod_q <= PW'($signed({1'b0, op_b}) - $signed({1'b0, op_a})) *
                  PW'($signed({1'b0, t_q}));
      end
      F_ADD: begin
        if (j < 3'd5) lr_q[j] <= lerp_res;
        else if (ysel) py_q <= lerp_res;
        else px_q <= lerp_res;
        step_q <= step_q + 4'd1;
      end
      default: ;
    endcase
  end

endmodule

@@ sv/bzp_back.sv @@
module bzp_back import bzp_pkg::*; #(
  parameter int unsigned FRAME_WIDTH  = 512,
  parameter int unsigned FRAME_HEIGHT = 512
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  output logic    clearing_o,
  input  logic    job_empty_i,
  input  job_t    job_i,
  output logic    job_pop_o,
  output logic    res_push_o,
  output result_t res_o,
  input  logic    res_full_i
);

  localparam int unsigned Depth = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int unsigned AW    = $clog2(Depth);

  back_state_e state_q, state_d;
  job_t              job_q;
  logic [8:0]        mask_q;
  logic [3:0]        nb_q;
  logic signed [CellW-1:0] cx_q, cy_q;
  logic [AW-1:0]     addr_q, clr_q;
  logic [33:0]       sq_q;
  logic [SqrtIn-1:0] v_q, root_q, bit_q;
  logic [17:0]       r_q;
  logic [35:0]       r2_q;
  logic [53:0]       r3_q;
  logic [61:0]       num_q;
  logic [7:0]        k_q, kb_q;
  logic [7:0]        rd_q;
  logic [7:0]        mem [Depth];

  logic [CoordW-1:0] cell_x, cell_y;
  logic signed [CellW-1:0] cur_x, cur_y;
  logic [8:0]        mask_d;
  logic signed [30:0] dfx, dfy;
  logic [16:0]       ax, ay;
  logic [SqrtIn-1:0] rb;
  logic [7:0]        trial, blend;
  logic              more_left;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [7:0]        mem_wd;

  function automatic logic in_frame(input logic signed [CellW-1:0] x,
                                    input logic signed [CellW-1:0] y);
    return !x[CellW-1] && !y[CellW-1] &&
           (x < $signed(CellW'(FRAME_WIDTH))) && (y < $signed(CellW'(FRAME_HEIGHT)));
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic signed [CellW-1:0] x,
                                            input logic signed [CellW-1:0] y);
    return AW'(32'(y) * 32'(FRAME_WIDTH) + 32'(x));
  endfunction

  always_comb begin
    cell_x = job_q.px[PosW-1 -: CoordW];
    cell_y = job_q.py[PosW-1 -: CoordW];
    cur_x  = $signed({5'b0, cell_x}) + CellW'(nb_dx(nb_q));
    cur_y  = $signed({5'b0, cell_y}) + CellW'(nb_dy(nb_q));
    for (int i = 0; i < 9; i++) begin
      mask_d[i] = in_frame($signed({5'b0, cell_x}) + CellW'(nb_dx(4'(i))),
                           $signed({5'b0, cell_y}) + CellW'(nb_dy(4'(i))));
    end
    dfx = $signed({6'b0, job_q.px}) - $signed({cx_q[CellW-1], cx_q, 16'h8000});
    dfy = $signed({6'b0, job_q.py}) - $signed({cy_q[CellW-1], cy_q, 16'h8000});
    ax  = dfx[30] ? 17'(-dfx) : dfx[16:0];
    ay  = dfy[30] ? 17'(-dfy) : dfy[16:0];
    rb  = root_q + bit_q;
    trial = k_q | kb_q;
    blend = (k_q > rd_q) ? k_q : rd_q;
    more_left = |(mask_q & ~((9'd2 << nb_q) - 9'd1));
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_CLEAR:   if (clr_q == AW'(Depth - 1)) state_d = B_IDLE;
      B_IDLE:    if (!job_empty_i) state_d = B_SETUP;
      B_SETUP:   state_d = (job_q.kind == KIND_READ) ? B_RD_WAIT : B_NB;
      B_NB:      state_d = mask_q[nb_q] ? B_SQX : B_NEXT;
      B_SQX:     state_d = B_SQY;
      B_SQY:     state_d = B_ROOT;
      B_ROOT:    if (bit_q == SqrtIn'(1)) state_d = B_DIFF;
      B_DIFF:    state_d = B_SQR;
      B_SQR:     state_d = B_CUBE;
      B_CUBE:    state_d = B_SCALE;
      B_SCALE:   state_d = B_SEARCH;
      B_SEARCH:  if (kb_q == 8'd1) state_d = B_WRITE;
      B_WRITE:   if (!res_full_i) state_d = B_NEXT;
      B_NEXT:    state_d = (nb_q == 4'(NbLast)) ? B_IDLE : B_NB;
      B_RD_WAIT: state_d = B_RD_EMIT;
      B_RD_EMIT: if (!res_full_i) state_d = B_IDLE;
      default:   state_d = B_IDLE;
    endcase
  end

  always_comb begin
    clearing_o = (state_q == B_CLEAR);
    job_pop_o  = (state_q == B_IDLE) && !job_empty_i;
    res_push_o = ((state_q == B_WRITE) || (state_q == B_RD_EMIT)) && !res_full_i;
    mem_we     = clearing_o || ((state_q == B_WRITE) && !res_full_i);
    mem_wa     = clearing_o ? clr_q : addr_q;
    mem_wd     = clearing_o ? 8'd0 : blend;
    if (state_q == B_RD_EMIT) begin
      res_o.x     = job_q.rx;
      res_o.y     = job_q.ry;
      res_o.value = mask_q[0] ? rd_q : 8'd0;
      res_o.last  = 1'b1;
    end else begin
      res_o.x     = cur_x[CoordW-1:0];
      res_o.y     = cur_y[CoordW-1:0];
      res_o.value = blend;
      res_o.last  = !more_left;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (clearing_o) clr_q <= clr_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      B_IDLE: if (!job_empty_i) job_q <= job_i;
      B_SETUP: begin
        nb_q <= 4'd0;
        if (job_q.kind == KIND_READ) begin
          mask_q <= {8'b0, in_frame($signed({5'b0, job_q.rx}), $signed({5'b0, job_q.ry}))};
          addr_q <= addr_of($signed({5'b0, job_q.rx}), $signed({5'b0, job_q.ry}));
        end else begin
          mask_q <= mask_d;
        end
      end
      B_NB: begin
        cx_q   <= cur_x;
        cy_q   <= cur_y;
        addr_q <= addr_of(cur_x, cur_y);
      end
      B_SQX: sq_q <= 34'(ax) * 34'(ax);
      B_SQY: begin
        v_q    <= SqrtIn'(sq_q) + SqrtIn'(34'(ay) * 34'(ay));
        root_q <= '0;
        bit_q  <= SqrtIn'(1) << 34;
      end
      B_ROOT: begin
        if (v_q >= rb) begin
          v_q    <= v_q - rb;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      B_DIFF: r_q <= (root_q < SqrtIn'(SQRT8_Q16)) ? 18'(SqrtIn'(SQRT8_Q16) - root_q) : 18'd0;
      B_SQR:  r2_q <= 36'(r_q) * 36'(r_q);
      B_CUBE: r3_q <= 54'(r2_q) * 54'(r_q);
      B_SCALE: begin
        num_q <= (62'(r3_q) << 8) - 62'(r3_q);
        k_q   <= 8'd0;
        kb_q  <= 8'h80;
      end
      B_SEARCH: begin
        // one intensity bit per cycle: largest k with k*S^3 <= 255*r^3
        if (64'(trial) * S3 <= 64'(num_q)) k_q <= trial;
        kb_q <= kb_q >> 1;
      end
      B_NEXT: nb_q <= nb_q + 4'd1;
      default: ;
    endcase
  end

  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_o |-> !job_pop_o) else $error("job taken during clear");
  a_root_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_DIFF) |-> (root_q < (SqrtIn'(1) << 18))) else $error("root too wide");
  a_push_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && state_q == B_WRITE) |-> mask_q[nb_q]) else $error("off-frame pixel emitted");
  a_write_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && !clearing_o) |-> res_push_o) else $error("write without transaction");

endmodule
